### rtl/f4el_pkg.sv
// shared types, constants and helpers for the eight-lane fletcher-4 checksum core
`default_nettype none

package f4el_pkg;

  localparam int LANE_COUNT = 8;
  localparam int WORD_W     = 32;
  localparam int SUM_W      = 64;
  localparam int WEIGHT_W   = 10;
  localparam int HALF_COUNT = 2;
  localparam int HALF_LANES = LANE_COUNT / HALF_COUNT;

  // power-of-eight scaling of the second, third and fourth lane sums
  localparam int SHIFT_B = 3;
  localparam int SHIFT_C = 6;
  localparam int SHIFT_D = 9;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // fixed merge weights, indexed by lane
  localparam weight_t W_LANE [LANE_COUNT] = '{0, 1, 2, 3, 4, 5, 6, 7};
  localparam weight_t W_CA   [LANE_COUNT] = '{0, 0, 1, 3, 6, 10, 15, 21};
  localparam weight_t W_CB   [LANE_COUNT] = '{28, 36, 44, 52, 60, 68, 76, 84};
  localparam weight_t W_DA   [LANE_COUNT] = '{0, 0, 0, 1, 4, 10, 20, 35};
  localparam weight_t W_DB   [LANE_COUNT] = '{56, 84, 120, 164, 216, 276, 344, 420};
  localparam weight_t W_DC   [LANE_COUNT] = '{448, 512, 576, 640, 704, 768, 832, 896};

  // input transaction: one 32-byte chunk
  typedef struct packed {
    word_t word_0;
    word_t word_1;
    word_t word_2;
    word_t word_3;
    word_t word_4;
    word_t word_5;
    word_t word_6;
    word_t word_7;
    logic  last_chunk;
  } in_data_t;

  // result transaction: the four serial sums
  typedef struct packed {
    sum_t sum_a;
    sum_t sum_b;
    sum_t sum_c;
    sum_t sum_d;
  } out_data_t;

  // cascaded sums held by one lane
  typedef struct packed {
    sum_t first_sum;
    sum_t second_sum;
    sum_t third_sum;
    sum_t fourth_sum;
  } lane_sums_t;

  // merge pipeline occupancy
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } mrg_status_t;

  // byte reversal within a 32-bit word
  function automatic word_t byte_swap(input word_t w);
    byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

### rtl/f4el_lane.sv
// one checksum lane: four cascaded 64-bit running sums
`default_nettype none

module f4el_lane (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 upd,
  input  wire logic                 clr,
  input  wire logic                 swap,
  input  wire f4el_pkg::word_t      word,
  output f4el_pkg::lane_sums_t      lane_out
);

  f4el_pkg::lane_sums_t sums_r;
  f4el_pkg::lane_sums_t sums_nxt;
  f4el_pkg::lane_sums_t base;
  f4el_pkg::sum_t       word_ext;
  logic                 clr_r;

  // optional byte reversal, then zero extension
  always_comb begin
    if (swap) begin
      word_ext = {{(f4el_pkg::SUM_W-f4el_pkg::WORD_W){1'b0}}, f4el_pkg::byte_swap(word)};
    end else begin
      word_ext = {{(f4el_pkg::SUM_W-f4el_pkg::WORD_W){1'b0}}, word};
    end
  end

  // a finished buffer stays visible to the merge; the next chunk starts from zero
  always_comb begin
    if (clr_r) begin
      base = '0;
    end else begin
      base = sums_r;
    end
  end

  // cascade: each sum absorbs the updated value of the one before it
  always_comb begin
    sums_nxt.first_sum  = base.first_sum  + word_ext;
    sums_nxt.second_sum = base.second_sum + sums_nxt.first_sum;
    sums_nxt.third_sum  = base.third_sum  + sums_nxt.second_sum;
    sums_nxt.fourth_sum = base.fourth_sum + sums_nxt.third_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
      clr_r  <= 1'b0;
    end else if (upd) begin
      sums_r <= sums_nxt;
      clr_r  <= clr;
    end
  end

  assign lane_out = sums_r;

endmodule

`default_nettype wire

### rtl/f4el_merge.sv
// merge pipeline: weighted lane terms, half sums, final result register
`default_nettype none

module f4el_merge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 load,
  input  wire f4el_pkg::lane_sums_t lanes [f4el_pkg::LANE_COUNT],
  output logic                      res_valid,
  output f4el_pkg::out_data_t       res_data,
  output f4el_pkg::mrg_status_t     status
);

  f4el_pkg::out_data_t term_nxt [f4el_pkg::LANE_COUNT];
  f4el_pkg::out_data_t term_r   [f4el_pkg::LANE_COUNT];
  f4el_pkg::out_data_t half_nxt [f4el_pkg::HALF_COUNT];
  f4el_pkg::out_data_t half_r   [f4el_pkg::HALF_COUNT];
  f4el_pkg::out_data_t res_nxt;
  f4el_pkg::out_data_t res_r;
  logic                pend_r;
  logic                v1_r;
  logic                v2_r;
  logic                res_valid_r;

  // per-lane weighted terms, constant weights only
  for (genvar i = 0; i < f4el_pkg::LANE_COUNT; i++) begin : g_term
    always_comb begin
      term_nxt[i].sum_a = lanes[i].first_sum;
      term_nxt[i].sum_b = (lanes[i].second_sum << f4el_pkg::SHIFT_B)
                        - f4el_pkg::sum_t'(lanes[i].first_sum
                                           * f4el_pkg::sum_t'(f4el_pkg::W_LANE[i]));
      term_nxt[i].sum_c = (lanes[i].third_sum << f4el_pkg::SHIFT_C)
                        - f4el_pkg::sum_t'(lanes[i].second_sum
                                           * f4el_pkg::sum_t'(f4el_pkg::W_CB[i]))
                        + f4el_pkg::sum_t'(lanes[i].first_sum
                                           * f4el_pkg::sum_t'(f4el_pkg::W_CA[i]));
      term_nxt[i].sum_d = (lanes[i].fourth_sum << f4el_pkg::SHIFT_D)
                        - f4el_pkg::sum_t'(lanes[i].third_sum
                                           * f4el_pkg::sum_t'(f4el_pkg::W_DC[i]))
                        + f4el_pkg::sum_t'(lanes[i].second_sum
                                           * f4el_pkg::sum_t'(f4el_pkg::W_DB[i]))
                        - f4el_pkg::sum_t'(lanes[i].first_sum
                                           * f4el_pkg::sum_t'(f4el_pkg::W_DA[i]));
    end
  end

  // sum of four lanes per half
  always_comb begin
    for (int h = 0; h < f4el_pkg::HALF_COUNT; h++) begin
      half_nxt[h] = '0;
      for (int k = 0; k < f4el_pkg::HALF_LANES; k++) begin
        half_nxt[h].sum_a = half_nxt[h].sum_a + term_r[h*f4el_pkg::HALF_LANES+k].sum_a;
        half_nxt[h].sum_b = half_nxt[h].sum_b + term_r[h*f4el_pkg::HALF_LANES+k].sum_b;
        half_nxt[h].sum_c = half_nxt[h].sum_c + term_r[h*f4el_pkg::HALF_LANES+k].sum_c;
        half_nxt[h].sum_d = half_nxt[h].sum_d + term_r[h*f4el_pkg::HALF_LANES+k].sum_d;
      end
    end
  end

  // final combine of the two halves
  always_comb begin
    res_nxt.sum_a = half_r[0].sum_a + half_r[1].sum_a;
    res_nxt.sum_b = half_r[0].sum_b + half_r[1].sum_b;
    res_nxt.sum_c = half_r[0].sum_c + half_r[1].sum_c;
    res_nxt.sum_d = half_r[0].sum_d + half_r[1].sum_d;
  end

  // pipeline valid bits, all stages move together; pend_r marks finished lane sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (en) begin
      pend_r      <= load;
      v1_r        <= pend_r;
      v2_r        <= v1_r;
      res_valid_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      half_r <= half_nxt;
      if (v2_r) begin
        res_r <= res_nxt;
      end
    end
  end

  assign res_valid       = res_valid_r;
  assign res_data        = res_r;
  assign status.s1_valid = v1_r;
  assign status.s2_valid = v2_r;

endmodule

`default_nettype wire

### rtl/fletcher4_eight_lane_checksum_core.sv
// top level of the eight-lane fletcher-4 checksum core
// Usage:
//  - in_valid/in_data/in_stall carry one 32-byte chunk per transaction as eight
//    32-bit words; word k feeds lane k. in_data.last_chunk ends a buffer.
//  - out_valid/out_data/out_stall carry one result per buffer: the serial
//    fletcher-4 sums A, B, C and D, each modulo 2^64.
//  - cfg_valid/cfg_data/cfg_ready write swap_bytes (1 = byte-reverse each word);
//    cfg_ready is always high. Write it only while the core is idle.
//  - throughput: one chunk per cycle while in_stall is low, set by the registered lane update.
//  - path of a result: once its last chunk is taken, the lane registers hold
//    the finished sums, then three merge stages (weighted lane terms, half
//    sums, result reg) carry them to out_data.
//  - the chunk after a last chunk starts its lanes from zero, so the next
//    buffer may start right behind it.
//  - when a result is held by out_stall the lanes and the merge pipeline
//    freeze together and in_stall is raised until the result is taken.
//  - reset (rst_n low, synchronous) clears all lanes, swap_bytes and the
//    pipeline valid bits.
`default_nettype none

module fletcher4_eight_lane_checksum_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire f4el_pkg::in_data_t  in_data,
  output logic                     in_stall,
  output logic                     out_valid,
  output f4el_pkg::out_data_t      out_data,
  input  wire logic                out_stall,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_data,
  output logic                     cfg_ready
);

  logic                   en;
  logic                   in_acc;
  logic                   last_acc;
  logic                   swap_r;
  f4el_pkg::word_t        words     [f4el_pkg::LANE_COUNT];
  f4el_pkg::lane_sums_t   lane_sums [f4el_pkg::LANE_COUNT];
  f4el_pkg::mrg_status_t  mrg_status;

  // whole datapath advances unless a result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign in_acc   = in_valid && en;
  assign last_acc = in_acc && in_data.last_chunk;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      swap_r <= cfg_data;
    end
  end

  // chunk words to lanes
  assign words[0] = in_data.word_0;
  assign words[1] = in_data.word_1;
  assign words[2] = in_data.word_2;
  assign words[3] = in_data.word_3;
  assign words[4] = in_data.word_4;
  assign words[5] = in_data.word_5;
  assign words[6] = in_data.word_6;
  assign words[7] = in_data.word_7;

  for (genvar i = 0; i < f4el_pkg::LANE_COUNT; i++) begin : g_lane
    f4el_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (in_acc),
      .clr      (in_data.last_chunk),
      .swap     (swap_r),
      .word     (words[i]),
      .lane_out (lane_sums[i])
    );
  end

  // merge of the lanes into the serial sums
  f4el_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .load      (last_acc),
    .lanes     (lane_sums),
    .res_valid (out_valid),
    .res_data  (out_data),
    .status    (mrg_status)
  );

  // with the pipeline moving, a last chunk has its result presented after the lane registers and the merge stages
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    last_acc ##1 en [*3] |=> out_valid)
    else $error("no result after last chunk");

  // a new result only comes out of the second merge stage
  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(mrg_status.s2_valid))
    else $error("result appeared without merge stage two");

  // a merge in flight never stalls while the output slot is free
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (mrg_status.s1_valid && !out_valid) |=> mrg_status.s2_valid)
    else $error("merge pipeline stalled with free output");

endmodule

`default_nettype wire
